// ===== design/kmsp_pkg.sv =====
package kmsp_pkg;

  localparam int MAX_K         = 8;
  localparam int ALPHABET_SIZE = 4;

  localparam int IDX_W      = 2 * MAX_K;
  localparam int ROW_W      = 16;
  localparam int BIT_W      = $clog2(ROW_W);
  localparam int ROW_ADDR_W = IDX_W - BIT_W;
  localparam int ROWS       = 1 << ROW_ADDR_W;

  localparam int K_W    = 4;
  localparam int CHAR_W = 8;
  localparam int TEXT_W = CHAR_W * MAX_K;
  localparam int MASK_W = ALPHABET_SIZE;

  localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

  localparam logic [1:0] NUC_A = 2'd0;
  localparam logic [1:0] NUC_C = 2'd1;
  localparam logic [1:0] NUC_G = 2'd2;
  localparam logic [1:0] NUC_T = 2'd3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_SIZE_ERR = 1'b1;

  localparam logic [K_W-1:0] KMER_SIZE_RST = K_W'(MAX_K);

  typedef logic [IDX_W-1:0]      kmer_idx_t;
  typedef logic [ROW_W-1:0]      row_t;
  typedef logic [ROW_ADDR_W-1:0] row_addr_t;

  typedef struct packed {
    logic      rd_a_en;
    row_addr_t rd_a_addr;
    logic      rd_b_en;
    row_addr_t rd_b_addr;
    logic      wr_en;
    row_addr_t wr_addr;
    row_t      wr_data;
  } bm_req_t;

  function automatic logic [1:0] letter_code(input logic [CHAR_W-1:0] ch);
    case (ch)
      CHAR_C:  return NUC_C;
      CHAR_G:  return NUC_G;
      CHAR_T:  return NUC_T;
      default: return NUC_A;
    endcase
  endfunction

endpackage

// ===== design/kmsp_if.sv =====
interface kmsp_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [kmsp_pkg::TEXT_W-1:0]   kmer_text;
  logic [kmsp_pkg::K_W-1:0]      kmer_length;

  modport source(output valid, operation, kmer_text, kmer_length, input ready);
  modport sink(input valid, operation, kmer_text, kmer_length, output ready);
endinterface

interface kmsp_out_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic                          present;
  logic [kmsp_pkg::MASK_W-1:0]   predecessor_mask;

  modport source(output valid, status, present, predecessor_mask, input ready);
  modport sink(input valid, status, present, predecessor_mask, output ready);
endinterface

// ===== design/kmsp_encode.sv =====
module kmsp_encode (
  input  logic [kmsp_pkg::TEXT_W-1:0] text_i,
  input  logic [kmsp_pkg::K_W-1:0]    k_i,
  output kmsp_pkg::kmer_idx_t         code_o
);

  kmsp_pkg::kmer_idx_t full;
  logic [4:0]          shamt;

  // first letter lands in the top digit, then shift down to k digits
  always_comb begin
    for (int i = 0; i < kmsp_pkg::MAX_K; i++) begin
      full[2*(kmsp_pkg::MAX_K-1-i) +: 2] =
        kmsp_pkg::letter_code(text_i[kmsp_pkg::CHAR_W*i +: kmsp_pkg::CHAR_W]);
    end
  end

  assign shamt  = 5'(kmsp_pkg::IDX_W) - {k_i, 1'b0};
  assign code_o = full >> shamt;

endmodule

// ===== design/kmsp_bitmap.sv =====
module kmsp_bitmap (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kmsp_pkg::bm_req_t req_i,
  output kmsp_pkg::row_t    rd_a_o,
  output kmsp_pkg::row_t    rd_b_o,
  output logic              busy_o
);

  kmsp_pkg::row_t      mem [kmsp_pkg::ROWS];
  kmsp_pkg::row_t      rd_a_q;
  kmsp_pkg::row_t      rd_b_q;
  kmsp_pkg::row_addr_t clr_addr_q;
  logic                clearing_q;

  // clearing sweep after reset, one row per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == '1) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_addr_q] <= '0;
    end else if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_a_en) begin
      rd_a_q <= mem[req_i.rd_a_addr];
    end
    if (req_i.rd_b_en) begin
      rd_b_q <= mem[req_i.rd_b_addr];
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;
  assign busy_o = clearing_q;

  a_sweep_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q && clr_addr_q != '1 |=> clearing_q && clr_addr_q == $past(clr_addr_q) + 1'b1)
    else $error("clear sweep did not advance");

  a_sweep_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clearing_q |=> !clearing_q)
    else $error("clear sweep restarted without reset");

endmodule

// ===== design/kmer_set_membership_with_predecessors_top.sv =====
// k-mer presence bitmap with predecessor lookup.
// in_i (valid/ready): one beat carries operation, kmer_text (8 ascii letters, first letter
// in the low byte) and kmer_length. out_o (valid/ready): one beat per input beat with
// status, present and predecessor_mask, in input order.
// kmer_size_we_i/kmer_size_i write k; write it only while no item is in flight.
// The bitmap is a 4096 x 16 bit memory with two registered read ports and one write port.
// After reset a clearing sweep zeroes it, one row per cycle, with in_i.ready low.
// kmer_size resets to 8. An insert reads its row in ST_RD0 and writes it back in ST_WR; a
// query reads its own row and the four predecessor rows over the two read ports in ST_RD0,
// ST_RD1 and ST_RD2; a query with a length mismatch goes straight to ST_DONE.
// One item is in flight at a time; the next beat is taken in the cycle the result is
// loaded into the output register. An insert's write lands before any later read.
// A stalled out_o holds its beat; the block finishes the current item and then waits
// with in_i.ready low until the output register frees up.
module kmer_set_membership_with_predecessors_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  kmsp_in_if.sink                      in_i,
  kmsp_out_if.source                   out_o,
  input  logic                         kmer_size_we_i,
  input  logic [kmsp_pkg::K_W-1:0]     kmer_size_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_WR,
    ST_DONE
  } state_e;

  state_e                       state_q;
  logic [kmsp_pkg::K_W-1:0]     kmer_size_q;
  logic [kmsp_pkg::K_W-1:0]     k_eff;
  logic [kmsp_pkg::K_W-1:0]     k_q;
  logic                         op_q;
  kmsp_pkg::kmer_idx_t          code_q;
  kmsp_pkg::kmer_idx_t          enc_code;
  logic                         status_q;
  logic                         pres_q;
  logic [kmsp_pkg::MASK_W-1:0]  mask_q;

  logic                         out_valid_q;
  logic                         out_status_q;
  logic                         out_present_q;
  logic [kmsp_pkg::MASK_W-1:0]  out_mask_q;

  logic                         bm_busy;
  kmsp_pkg::bm_req_t            bm_req;
  kmsp_pkg::row_t               rd_a;
  kmsp_pkg::row_t               rd_b;

  logic                         accept;
  logic                         out_free;
  logic                         size_err;
  state_e                       first_state;
  kmsp_pkg::kmer_idx_t          tail;
  logic [4:0]                   psh;
  kmsp_pkg::kmer_idx_t          pred_idx [kmsp_pkg::ALPHABET_SIZE];

  always_comb begin
    if (kmer_size_q == '0) begin
      k_eff = kmsp_pkg::K_W'(1);
    end else if (kmer_size_q > kmsp_pkg::K_W'(kmsp_pkg::MAX_K)) begin
      k_eff = kmsp_pkg::K_W'(kmsp_pkg::MAX_K);
    end else begin
      k_eff = kmer_size_q;
    end
  end

  kmsp_encode u_encode (
    .text_i (in_i.kmer_text),
    .k_i    (k_eff),
    .code_o (enc_code)
  );

  kmsp_bitmap u_bitmap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (bm_req),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b),
    .busy_o (bm_busy)
  );

  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = !bm_busy && (state_q == ST_IDLE || (state_q == ST_DONE && out_free));
  assign accept     = in_i.valid && in_i.ready;
  assign size_err   = (in_i.operation == kmsp_pkg::OP_QUERY) && (in_i.kmer_length != k_eff);
  assign first_state = size_err ? ST_DONE : ST_RD0;

  // predecessor n: digit n on top, then the first k-1 letters
  assign tail = code_q >> 2;
  assign psh  = {k_q - 4'd1, 1'b0};

  always_comb begin
    for (int n = 0; n < kmsp_pkg::ALPHABET_SIZE; n++) begin
      pred_idx[n] = (kmsp_pkg::kmer_idx_t'(n) << psh) | tail;
    end
  end

  always_comb begin
    bm_req = '0;
    case (state_q)
      ST_RD0: begin
        bm_req.rd_a_en   = 1'b1;
        bm_req.rd_a_addr = code_q[kmsp_pkg::IDX_W-1:kmsp_pkg::BIT_W];
        bm_req.rd_b_en   = (op_q == kmsp_pkg::OP_QUERY);
        bm_req.rd_b_addr = pred_idx[0][kmsp_pkg::IDX_W-1:kmsp_pkg::BIT_W];
      end
      ST_RD1: begin
        bm_req.rd_a_en   = 1'b1;
        bm_req.rd_a_addr = pred_idx[1][kmsp_pkg::IDX_W-1:kmsp_pkg::BIT_W];
        bm_req.rd_b_en   = 1'b1;
        bm_req.rd_b_addr = pred_idx[2][kmsp_pkg::IDX_W-1:kmsp_pkg::BIT_W];
      end
      ST_RD2: begin
        bm_req.rd_a_en   = 1'b1;
        bm_req.rd_a_addr = pred_idx[3][kmsp_pkg::IDX_W-1:kmsp_pkg::BIT_W];
      end
      ST_WR: begin
        bm_req.wr_en   = 1'b1;
        bm_req.wr_addr = code_q[kmsp_pkg::IDX_W-1:kmsp_pkg::BIT_W];
        bm_req.wr_data = rd_a | (kmsp_pkg::row_t'(1) << code_q[kmsp_pkg::BIT_W-1:0]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      kmer_size_q <= kmsp_pkg::KMER_SIZE_RST;
    end else begin
      if (kmer_size_we_i) begin
        kmer_size_q <= kmer_size_i;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        op_q     <= in_i.operation;
        code_q   <= enc_code;
        k_q      <= k_eff;
        status_q <= size_err ? kmsp_pkg::STATUS_SIZE_ERR : kmsp_pkg::STATUS_OK;
        pres_q   <= 1'b0;
        mask_q   <= '0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= first_state;
          end
        end
        ST_RD0: begin
          state_q <= (op_q == kmsp_pkg::OP_QUERY) ? ST_RD1 : ST_WR;
        end
        ST_RD1: begin
          pres_q    <= rd_a[code_q[kmsp_pkg::BIT_W-1:0]];
          mask_q[0] <= rd_b[pred_idx[0][kmsp_pkg::BIT_W-1:0]];
          state_q   <= ST_RD2;
        end
        ST_RD2: begin
          mask_q[1] <= rd_a[pred_idx[1][kmsp_pkg::BIT_W-1:0]];
          mask_q[2] <= rd_b[pred_idx[2][kmsp_pkg::BIT_W-1:0]];
          state_q   <= ST_RD3;
        end
        ST_RD3: begin
          mask_q[3] <= rd_a[pred_idx[3][kmsp_pkg::BIT_W-1:0]];
          state_q   <= ST_DONE;
        end
        ST_WR: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_status_q  <= status_q;
            out_present_q <= pres_q;
            out_mask_q    <= pres_q ? mask_q : '0;
            state_q       <= accept ? first_state : ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.status           = out_status_q;
  assign out_o.present          = out_present_q;
  assign out_o.predecessor_mask = out_mask_q;

  a_no_beat_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bm_busy |-> !in_i.ready)
    else $error("input taken during bitmap clear");

  a_write_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bm_req.wr_en |-> !bm_req.rd_a_en && !bm_req.rd_b_en && $past(state_q) == ST_RD0)
    else $error("bitmap write not preceded by its row read");

  a_mask_needs_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.predecessor_mask != '0 |-> out_o.present)
    else $error("predecessor mask on an absent k-mer");

  a_error_not_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status == kmsp_pkg::STATUS_SIZE_ERR |-> !out_o.present)
    else $error("size error reported as present");

endmodule
